>>> hdl/swbm_pkg.sv
// Shared types, codes and constants of the single-wire bus master.
package swbm_pkg;

   localparam int TIMER_BITS = 20;
   localparam int LONG_BITS  = 20;
   localparam int SHORT_BITS = 10;

   // Operation codes carried in the request tuser field.
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_RESET = 3'd1;
   localparam logic [2:0] OP_READ  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_POWER = 3'd4;

   // Configuration register indexes.
   localparam logic [2:0] CSR_RESET_LOW   = 3'd0;
   localparam logic [2:0] CSR_FIRST_WAIT  = 3'd1;
   localparam logic [2:0] CSR_SECOND_WAIT = 3'd2;
   localparam logic [2:0] CSR_TAIL_WAIT   = 3'd3;
   localparam logic [2:0] CSR_READ_WAIT   = 3'd4;
   localparam logic [2:0] CSR_WR_PULSE    = 3'd5;
   localparam logic [2:0] CSR_WR_SLOT     = 3'd6;
   localparam logic [2:0] CSR_POWER       = 3'd7;

   // Reset status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_RESP  = 2'd1;
   localparam logic [1:0] STATUS_STUCK_LO = 2'd2;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_RST_LOW  = 4'd1,
      PH_RST_W1   = 4'd2,
      PH_RST_W2   = 4'd3,
      PH_RST_TAIL = 4'd4,
      PH_RD_RISE  = 4'd5,
      PH_RD_DELAY = 4'd6,
      PH_RD_FALL  = 4'd7,
      PH_WR_PULSE = 4'd8,
      PH_WR_SLOT  = 4'd9,
      PH_POWER    = 4'd10
   } phase_type;

   typedef struct packed {
      logic [LONG_BITS-1:0]  reset_low_time;
      logic [SHORT_BITS-1:0] first_sample_wait;
      logic [SHORT_BITS-1:0] second_sample_wait;
      logic [SHORT_BITS-1:0] reset_tail_wait;
      logic [SHORT_BITS-1:0] read_sample_wait;
      logic [SHORT_BITS-1:0] write_pulse_time;
      logic [SHORT_BITS-1:0] write_slot_time;
      logic [LONG_BITS-1:0]  power_time;
   } cfg_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [1:0] reset_status;
      logic       done_res;
      logic       busy_res;
      logic       drive_level;
      logic       drive_enable;
   } result_type;

   // Interval lengths are cut to the timer width when loaded.
   function automatic logic [TIMER_BITS-1:0] timer_load(input logic [LONG_BITS-1:0] v);
      logic [31:0] wide;
      wide = 32'(v);
      return wide[TIMER_BITS-1:0];
   endfunction

endpackage

>>> hdl/single_wire_bus_master_top.sv
// Top level of the single-wire bus master: ports, sequencer and result register.
//
// Each request is one microsecond tick and yields exactly one response that
// shows the bus drive and status after that tick. A request is taken whenever
// the output register is empty or being drained; the sequencer updates its
// phase, interval timer and shift register in the same cycle and the response
// is registered in a single output register. That register is refilled in the
// cycle it is drained, so the block sustains one request per clock whenever
// the response side keeps up. Configuration writes take effect on the next
// request and are meant to be made while no operation is in progress.
module single_wire_bus_master_top (
   input  logic        clock,
   input  logic        reset,
   // Request: tdata = write_data[7:0], line_level[8], zero fill [15:9].
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // Request: tuser = operation[2:0].
   input  logic [2:0]  req_tuser,
   // Response: tdata = drive_enable[0], drive_level[1], busy_res[2], done_res[3],
   // reset_status[5:4], read_data[13:6], zero fill [15:14].
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_data
);

   swbm_pkg::cfg_type    cfg;
   swbm_pkg::result_type result;
   swbm_pkg::result_type rsp_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 step;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   swbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   swbm_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .operation  (req_tuser),
      .write_data (req_tdata[7:0]),
      .line_level (req_tdata[8]),
      .cfg        (cfg),
      .result     (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

   // A finished operation never reports busy on the same tick.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> !rsp_tdata[2])
      else $error("done and busy set in the same response");

   // A high level is only ever driven, never merely requested while released.
   a_level_needs_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0])
      else $error("drive level set while drive is disabled");

   // Every accepted request yields a response in the next cycle.
   a_request_gives_response: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request produced no response");

   // A drained response with no new request leaves the output empty.
   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !req_tvalid |=> !rsp_tvalid)
      else $error("response repeated after being taken");

endmodule

>>> hdl/swbm_csr.sv
// Configuration register file of the single-wire bus master.
module swbm_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [19:0]          csr_data,
   output swbm_pkg::cfg_type    cfg
);

   swbm_pkg::cfg_type cfg_ff;
   swbm_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            swbm_pkg::CSR_RESET_LOW:   cfg_in.reset_low_time     = csr_data;
            swbm_pkg::CSR_FIRST_WAIT:  cfg_in.first_sample_wait  = csr_data[9:0];
            swbm_pkg::CSR_SECOND_WAIT: cfg_in.second_sample_wait = csr_data[9:0];
            swbm_pkg::CSR_TAIL_WAIT:   cfg_in.reset_tail_wait    = csr_data[9:0];
            swbm_pkg::CSR_READ_WAIT:   cfg_in.read_sample_wait   = csr_data[9:0];
            swbm_pkg::CSR_WR_PULSE:    cfg_in.write_pulse_time   = csr_data[9:0];
            swbm_pkg::CSR_WR_SLOT:     cfg_in.write_slot_time    = csr_data[9:0];
            swbm_pkg::CSR_POWER:       cfg_in.power_time         = csr_data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_time     <= 20'd18000;
         cfg_ff.first_sample_wait  <= 10'd40;
         cfg_ff.second_sample_wait <= 10'd80;
         cfg_ff.reset_tail_wait    <= 10'd80;
         cfg_ff.read_sample_wait   <= 10'd30;
         cfg_ff.write_pulse_time   <= 10'd2;
         cfg_ff.write_slot_time    <= 10'd120;
         cfg_ff.power_time         <= 20'd750000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hdl/swbm_seq.sv
// Bus sequencer: phase state machine, interval timer and bit shifter.
module swbm_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [2:0]            operation,
   input  logic [7:0]            write_data,
   input  logic                  line_level,
   input  swbm_pkg::cfg_type     cfg,
   output swbm_pkg::result_type  result
);

   localparam int TB = swbm_pkg::TIMER_BITS;

   swbm_pkg::phase_type phase_ff, phase_in;
   logic [TB-1:0]       time_left_ff, time_left_in;
   logic [3:0]          bit_index_ff, bit_index_in;
   logic [7:0]          shift_ff, shift_in;
   logic [1:0]          status_ff, status_in;
   logic [7:0]          last_read_ff, last_read_in;
   logic                done;
   logic                ends;
   logic [3:0]          bit_next;

   assign bit_next = bit_index_ff + 4'd1;

   always_comb begin
      phase_in     = phase_ff;
      time_left_in = time_left_ff;
      bit_index_in = bit_index_ff;
      shift_in     = shift_ff;
      status_in    = status_ff;
      last_read_in = last_read_ff;
      done         = 1'b0;

      // A timed interval ends once at most one tick remains.
      ends = (time_left_ff <= TB'(1));
      if (phase_ff != swbm_pkg::PH_IDLE && phase_ff != swbm_pkg::PH_RD_RISE &&
          phase_ff != swbm_pkg::PH_RD_FALL) begin
         time_left_in = ends ? '0 : time_left_ff - TB'(1);
      end

      unique case (phase_ff)
         swbm_pkg::PH_IDLE: begin
            case (operation)
               swbm_pkg::OP_RESET: begin
                  phase_in     = swbm_pkg::PH_RST_LOW;
                  time_left_in = swbm_pkg::timer_load(cfg.reset_low_time);
               end
               swbm_pkg::OP_READ: begin
                  phase_in     = swbm_pkg::PH_RD_RISE;
                  time_left_in = '0;
                  bit_index_in = '0;
                  shift_in     = '0;
               end
               swbm_pkg::OP_WRITE: begin
                  phase_in     = swbm_pkg::PH_WR_PULSE;
                  shift_in     = write_data;
                  bit_index_in = '0;
                  time_left_in = swbm_pkg::timer_load(20'(cfg.write_pulse_time));
               end
               swbm_pkg::OP_POWER: begin
                  phase_in     = swbm_pkg::PH_POWER;
                  time_left_in = swbm_pkg::timer_load(cfg.power_time);
               end
               default: phase_in = swbm_pkg::PH_IDLE;
            endcase
         end
         swbm_pkg::PH_RST_LOW: begin
            if (ends) begin
               phase_in     = swbm_pkg::PH_RST_W1;
               time_left_in = swbm_pkg::timer_load(20'(cfg.first_sample_wait));
            end
         end
         swbm_pkg::PH_RST_W1: begin
            if (ends) begin
               if (line_level) begin
                  status_in = swbm_pkg::STATUS_NO_RESP;
                  phase_in  = swbm_pkg::PH_IDLE;
                  done      = 1'b1;
               end else begin
                  phase_in     = swbm_pkg::PH_RST_W2;
                  time_left_in = swbm_pkg::timer_load(20'(cfg.second_sample_wait));
               end
            end
         end
         swbm_pkg::PH_RST_W2: begin
            if (ends) begin
               if (!line_level) begin
                  status_in = swbm_pkg::STATUS_STUCK_LO;
                  phase_in  = swbm_pkg::PH_IDLE;
                  done      = 1'b1;
               end else begin
                  phase_in     = swbm_pkg::PH_RST_TAIL;
                  time_left_in = swbm_pkg::timer_load(20'(cfg.reset_tail_wait));
               end
            end
         end
         swbm_pkg::PH_RST_TAIL: begin
            if (ends) begin
               status_in = swbm_pkg::STATUS_OK;
               phase_in  = swbm_pkg::PH_IDLE;
               done      = 1'b1;
            end
         end
         swbm_pkg::PH_RD_RISE: begin
            if (line_level) begin
               phase_in     = swbm_pkg::PH_RD_DELAY;
               time_left_in = swbm_pkg::timer_load(20'(cfg.read_sample_wait));
            end
         end
         swbm_pkg::PH_RD_DELAY: begin
            if (ends) begin
               shift_in = {shift_ff[6:0], line_level};
               phase_in = swbm_pkg::PH_RD_FALL;
            end
         end
         swbm_pkg::PH_RD_FALL: begin
            if (!line_level) begin
               bit_index_in = bit_next;
               if (bit_next >= 4'd8) begin
                  last_read_in = shift_ff;
                  phase_in     = swbm_pkg::PH_IDLE;
                  done         = 1'b1;
               end else begin
                  phase_in = swbm_pkg::PH_RD_RISE;
               end
            end
         end
         swbm_pkg::PH_WR_PULSE: begin
            if (ends) begin
               phase_in     = swbm_pkg::PH_WR_SLOT;
               time_left_in = swbm_pkg::timer_load(20'(cfg.write_slot_time));
            end
         end
         swbm_pkg::PH_WR_SLOT: begin
            if (ends) begin
               shift_in     = {1'b0, shift_ff[7:1]};
               bit_index_in = bit_next;
               if (bit_next >= 4'd8) begin
                  phase_in = swbm_pkg::PH_IDLE;
                  done     = 1'b1;
               end else begin
                  phase_in     = swbm_pkg::PH_WR_PULSE;
                  time_left_in = swbm_pkg::timer_load(20'(cfg.write_pulse_time));
               end
            end
         end
         swbm_pkg::PH_POWER: begin
            if (ends) begin
               phase_in = swbm_pkg::PH_IDLE;
               done     = 1'b1;
            end
         end
         default: phase_in = swbm_pkg::PH_IDLE;
      endcase

      // The result shows the drive of the phase entered on this tick.
      result.drive_enable = 1'b0;
      result.drive_level  = 1'b0;
      case (phase_in)
         swbm_pkg::PH_RST_LOW, swbm_pkg::PH_WR_PULSE: result.drive_enable = 1'b1;
         swbm_pkg::PH_WR_SLOT: begin
            result.drive_enable = 1'b1;
            result.drive_level  = shift_in[0];
         end
         swbm_pkg::PH_POWER: begin
            result.drive_enable = 1'b1;
            result.drive_level  = 1'b1;
         end
         default: result.drive_enable = 1'b0;
      endcase
      result.busy_res     = (phase_in != swbm_pkg::PH_IDLE);
      result.done_res     = done;
      result.reset_status = status_in;
      result.read_data    = last_read_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= swbm_pkg::PH_IDLE;
         time_left_ff <= '0;
         bit_index_ff <= '0;
         shift_ff     <= '0;
         status_ff    <= '0;
         last_read_ff <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         time_left_ff <= time_left_in;
         bit_index_ff <= bit_index_in;
         shift_ff     <= shift_in;
         status_ff    <= status_in;
         last_read_ff <= last_read_in;
      end
   end

endmodule

>>> tb/sv/swbm_checker.sv
// Checker for the single-wire bus master: mirrors the sequencer and compares every response.
module swbm_checker
   import swbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_data,
   output int          mismatch_count,
   output int          rsp_outstanding,
   output int          ops_started,
   output logic        seq_busy
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [19:0] SHORT_MASK = (20'd1 << SHORT_BITS) - 20'd1;
   localparam int          SHOW_LIMIT = 40;

   logic [19:0] interval_reg [0:7];
   phase_type   seq_phase;
   logic [31:0] ticks_left;
   logic [3:0]  bit_count;
   logic [7:0]  shift_reg;
   logic [1:0]  last_status;
   logic [7:0]  last_byte;
   result_type  expected_rsp [$];
   int          fail_total;
   int          started_total;

   initial begin
      mismatch_count  = 0;
      rsp_outstanding = 0;
      ops_started     = 0;
      seq_busy        = 1'b0;
   end

   function automatic void start_interval(input phase_type ph, input logic [2:0] idx);
      logic [63:0] wide;
      wide       = 64'(interval_reg[idx]) & ((64'd1 << TIMER_BITS) - 64'd1);
      seq_phase  = ph;
      ticks_left = wide[31:0];
   endfunction

   // An interval ends on the tick where at most one tick of it remains.
   function automatic logic interval_over();
      if (ticks_left <= 32'd1) begin
         ticks_left = '0;
         return 1'b1;
      end
      ticks_left = ticks_left - 32'd1;
      return 1'b0;
   endfunction

   function automatic void compare_field(input string label, input int want, input int got);
      if (want != got) begin
         fail_total = fail_total + 1;
         if (fail_total <= SHOW_LIMIT)
            $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
      end
   endfunction

   always @(posedge clock) begin : track
      result_type got_rsp;
      result_type want_rsp;
      result_type next_rsp;
      logic [2:0] op;
      logic [7:0] wdata;
      logic       line;
      logic       finished;
      if (reset) begin
         interval_reg[CSR_RESET_LOW]   = 20'd18000;
         interval_reg[CSR_FIRST_WAIT]  = 20'd40;
         interval_reg[CSR_SECOND_WAIT] = 20'd80;
         interval_reg[CSR_TAIL_WAIT]   = 20'd80;
         interval_reg[CSR_READ_WAIT]   = 20'd30;
         interval_reg[CSR_WR_PULSE]    = 20'd2;
         interval_reg[CSR_WR_SLOT]     = 20'd120;
         interval_reg[CSR_POWER]       = 20'd750000;
         seq_phase     = PH_IDLE;
         ticks_left    = '0;
         bit_count     = '0;
         shift_reg     = '0;
         last_status   = STATUS_OK;
         last_byte     = '0;
         expected_rsp.delete();
         fail_total    = 0;
         started_total = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_RESET_LOW || csr_index == CSR_POWER)
               interval_reg[csr_index] = csr_data;
            else
               interval_reg[csr_index] = csr_data & SHORT_MASK;
         end

         // Responses are matched before this edge's request is queued, since a
         // response can never belong to a request taken at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            got_rsp = rsp_tdata[13:0];
            if (expected_rsp.size() == 0) begin
               fail_total = fail_total + 1;
               if (fail_total <= SHOW_LIMIT)
                  $display("%0t ns: response expected none, got %h", $time, rsp_tdata);
            end else begin
               want_rsp = expected_rsp.pop_front();
               compare_field("drive_enable", want_rsp.drive_enable, got_rsp.drive_enable);
               compare_field("drive_level", want_rsp.drive_level, got_rsp.drive_level);
               compare_field("busy_res", want_rsp.busy_res, got_rsp.busy_res);
               compare_field("done_res", want_rsp.done_res, got_rsp.done_res);
               compare_field("reset_status", want_rsp.reset_status, got_rsp.reset_status);
               compare_field("read_data", want_rsp.read_data, got_rsp.read_data);
               compare_field("zero fill", 0, rsp_tdata[15:14]);
            end
         end

         if (req_tvalid && req_tready) begin
            op       = req_tuser;
            wdata    = req_tdata[7:0];
            line     = req_tdata[8];
            finished = 1'b0;
            if (seq_phase == PH_IDLE) begin
               case (op)
                  OP_RESET: begin
                     start_interval(PH_RST_LOW, CSR_RESET_LOW);
                     started_total = started_total + 1;
                  end
                  OP_READ: begin
                     seq_phase     = PH_RD_RISE;
                     ticks_left    = '0;
                     bit_count     = '0;
                     shift_reg     = '0;
                     started_total = started_total + 1;
                  end
                  OP_WRITE: begin
                     shift_reg     = wdata;
                     bit_count     = '0;
                     start_interval(PH_WR_PULSE, CSR_WR_PULSE);
                     started_total = started_total + 1;
                  end
                  OP_POWER: begin
                     start_interval(PH_POWER, CSR_POWER);
                     started_total = started_total + 1;
                  end
                  default: ;
               endcase
            end else begin
               case (seq_phase)
                  PH_RST_LOW: begin
                     if (interval_over())
                        start_interval(PH_RST_W1, CSR_FIRST_WAIT);
                  end
                  PH_RST_W1: begin
                     if (interval_over()) begin
                        if (line) begin
                           last_status = STATUS_NO_RESP;
                           seq_phase   = PH_IDLE;
                           finished    = 1'b1;
                        end else begin
                           start_interval(PH_RST_W2, CSR_SECOND_WAIT);
                        end
                     end
                  end
                  PH_RST_W2: begin
                     if (interval_over()) begin
                        if (!line) begin
                           last_status = STATUS_STUCK_LO;
                           seq_phase   = PH_IDLE;
                           finished    = 1'b1;
                        end else begin
                           start_interval(PH_RST_TAIL, CSR_TAIL_WAIT);
                        end
                     end
                  end
                  PH_RST_TAIL: begin
                     if (interval_over()) begin
                        last_status = STATUS_OK;
                        seq_phase   = PH_IDLE;
                        finished    = 1'b1;
                     end
                  end
                  PH_RD_RISE: begin
                     if (line)
                        start_interval(PH_RD_DELAY, CSR_READ_WAIT);
                  end
                  PH_RD_DELAY: begin
                     if (interval_over()) begin
                        shift_reg = {shift_reg[6:0], line};
                        seq_phase = PH_RD_FALL;
                     end
                  end
                  PH_RD_FALL: begin
                     if (!line) begin
                        bit_count = bit_count + 4'd1;
                        if (bit_count >= 4'd8) begin
                           last_byte = shift_reg;
                           seq_phase = PH_IDLE;
                           finished  = 1'b1;
                        end else begin
                           seq_phase = PH_RD_RISE;
                        end
                     end
                  end
                  PH_WR_PULSE: begin
                     if (interval_over())
                        start_interval(PH_WR_SLOT, CSR_WR_SLOT);
                  end
                  PH_WR_SLOT: begin
                     if (interval_over()) begin
                        shift_reg = shift_reg >> 1;
                        bit_count = bit_count + 4'd1;
                        if (bit_count >= 4'd8) begin
                           seq_phase = PH_IDLE;
                           finished  = 1'b1;
                        end else begin
                           start_interval(PH_WR_PULSE, CSR_WR_PULSE);
                        end
                     end
                  end
                  PH_POWER: begin
                     if (interval_over()) begin
                        seq_phase = PH_IDLE;
                        finished  = 1'b1;
                     end
                  end
                  default: seq_phase = PH_IDLE;
               endcase
            end

            next_rsp = '0;
            case (seq_phase)
               PH_RST_LOW, PH_WR_PULSE: next_rsp.drive_enable = 1'b1;
               PH_WR_SLOT: begin
                  next_rsp.drive_enable = 1'b1;
                  next_rsp.drive_level  = shift_reg[0];
               end
               PH_POWER: begin
                  next_rsp.drive_enable = 1'b1;
                  next_rsp.drive_level  = 1'b1;
               end
               default: ;
            endcase
            next_rsp.busy_res     = (seq_phase != PH_IDLE);
            next_rsp.done_res     = finished;
            next_rsp.reset_status = last_status;
            next_rsp.read_data    = last_byte;
            expected_rsp.push_back(next_rsp);
         end
      end
      mismatch_count  <= fail_total;
      rsp_outstanding <= expected_rsp.size();
      ops_started     <= started_total;
      seq_busy        <= (seq_phase != PH_IDLE);
   end

endmodule

>>> tb/sv/testbench.sv
// Top of the single-wire bus master testbench: clock, reset, request and register stimulus.
module testbench;
   import swbm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [19:0] csr_data;

   int          mismatch_count;
   int          rsp_outstanding;
   int          ops_started;
   logic        seq_busy;

   int          send_left;
   logic        send_quiet;

   single_wire_bus_master_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   swbm_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .rsp_outstanding (rsp_outstanding),
      .ops_started     (ops_started),
      .seq_busy        (seq_busy)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles = cycles + 1;
         if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Response side: random hold-offs with quiet stretches, plus one long stall.
   initial begin : sink
      int   hold;
      int   seen;
      int   quiet_left;
      logic quiet;
      hold       = 0;
      seen       = 0;
      quiet_left = 0;
      quiet      = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            seen = seen + 1;
            if (quiet_left == 0) begin
               quiet_left = 80;
               quiet      = ($urandom_range(0, 2) == 0);
            end
            quiet_left = quiet_left - 1;
            hold = quiet ? 0 : $urandom_range(0, 8);
            // Long enough that the output register fills and requests back up.
            if (seen == 700)
               hold = 400;
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold = hold - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offers one request and returns at the edge where it was taken, valid still high.
   task automatic send_item(input logic [2:0] op, input logic [7:0] wdata, input logic line);
      int gap;
      if (send_left == 0) begin
         send_left  = 100;
         send_quiet = ($urandom_range(0, 2) == 0);
      end
      send_left = send_left - 1;
      gap = send_quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, line, wdata};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Plain ticks until the sequencer is idle again; busy lags by one request.
   task automatic run_out();
      send_item(OP_TICK, 8'($urandom), 1'($urandom));
      while (seq_busy)
         send_item(OP_TICK, 8'($urandom), 1'($urandom));
   endtask

   task automatic quiesce();
      run_out();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (rsp_outstanding != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [19:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_timing(input logic [19:0] low_time, input logic [19:0] first_wait,
                             input logic [19:0] second_wait, input logic [19:0] tail_wait,
                             input logic [19:0] read_wait, input logic [19:0] pulse_time,
                             input logic [19:0] slot_time, input logic [19:0] power_ticks);
      write_reg(CSR_RESET_LOW, low_time);
      write_reg(CSR_FIRST_WAIT, first_wait);
      write_reg(CSR_SECOND_WAIT, second_wait);
      write_reg(CSR_TAIL_WAIT, tail_wait);
      write_reg(CSR_READ_WAIT, read_wait);
      write_reg(CSR_WR_PULSE, pulse_time);
      write_reg(CSR_WR_SLOT, slot_time);
      write_reg(CSR_POWER, power_ticks);
   endtask

   // Short value with junk above the register width, which must be dropped.
   function automatic logic [19:0] short_value(input int lim);
      return {10'($urandom), 10'($urandom_range(0, lim))};
   endfunction

   function automatic logic [19:0] long_value(input int lim);
      return 20'($urandom_range(0, lim));
   endfunction

   task automatic random_timing(input int lim);
      set_timing(long_value(lim), short_value(lim), short_value(lim), short_value(lim),
                 short_value(lim), short_value(lim), short_value(lim), long_value(lim));
   endtask

   function automatic logic [2:0] pick_op(input logic rw_only);
      if (rw_only)
         return $urandom_range(0, 1) ? OP_READ : OP_WRITE;
      case ($urandom_range(0, 9))
         0, 1:    return OP_RESET;
         2, 3, 4: return OP_READ;
         5, 6, 7: return OP_WRITE;
         8:       return OP_POWER;
         default: return OP_POWER + 3'($urandom_range(1, 3));
      endcase
   endfunction

   // Commands arrive on a quarter of the ticks; those landing while busy are dropped.
   task automatic run_random(input int count, input logic rw_only);
      int       target;
      logic [2:0] op;
      target = ops_started + count;
      while (ops_started < target) begin
         op = ($urandom_range(0, 3) == 0) ? pick_op(rw_only) : OP_TICK;
         send_item(op, 8'($urandom), 1'($urandom));
      end
      quiesce();
   endtask

   // With all intervals at zero the first reset sample falls on the second tick
   // after the command and the second sample on the third.
   task automatic reset_with(input logic first_level, input logic second_level);
      send_item(OP_RESET, 8'($urandom), 1'($urandom));
      send_item(OP_TICK, 8'($urandom), first_level);
      send_item(OP_TICK, 8'($urandom), first_level);
      send_item(OP_TICK, 8'($urandom), second_level);
      run_out();
   endtask

   initial begin : stimulus
      int limits [4];
      limits = '{3, 7, 0, 5};
      send_left  = 0;
      send_quiet = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_TICK;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_RESET_LOW;
      csr_data   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Timing as it comes out of reset.
      send_item(OP_READ, 8'($urandom), 1'($urandom));
      quiesce();

      // Every interval zero, so each lasts a single tick.
      set_timing('0, '0, '0, '0, '0, '0, '0, '0);
      send_item(OP_TICK, 8'($urandom), 1'($urandom));
      reset_with(1'b1, 1'b1);
      reset_with(1'b0, 1'b0);
      reset_with(1'b0, 1'b1);
      // A read held up first waiting for the rise and then for the fall.
      send_item(OP_READ, 8'($urandom), 1'b0);
      repeat (20) send_item(OP_TICK, 8'($urandom), 1'b0);
      repeat (20) send_item(OP_TICK, 8'($urandom), 1'b1);
      run_out();
      send_item(OP_WRITE, 8'h00, 1'($urandom));
      run_out();
      send_item(OP_WRITE, 8'hFF, 1'($urandom));
      run_out();
      send_item(OP_WRITE, 8'hA5, 1'($urandom));
      send_item(OP_READ, 8'($urandom), 1'($urandom));
      run_out();
      send_item(OP_POWER, 8'($urandom), 1'($urandom));
      send_item(OP_RESET, 8'($urandom), 1'($urandom));
      run_out();
      send_item(OP_POWER + 3'd1, 8'($urandom), 1'($urandom));
      send_item(OP_POWER + 3'd2, 8'($urandom), 1'($urandom));
      send_item(OP_POWER + 3'd3, 8'($urandom), 1'($urandom));
      quiesce();

      foreach (limits[i]) begin
         random_timing(limits[i]);
         run_random(6, 1'b0);
      end

      // Long intervals at their maximum; only reads and writes keep the run short.
      set_timing(20'hFFFFF, short_value(7), short_value(7), short_value(7),
                 short_value(7), short_value(7), short_value(7), 20'hFFFFF);
      run_random(2, 1'b1);

      repeat (2) @(posedge clock);
      while (rsp_outstanding != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && rsp_outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
